>>> design/pfla_pkg.sv
// Shared constants, codes and types of the LIFO page allocator.
// Used by pfla_stack, pfla_exec and page_free_list_allocator_core.
package pfla_pkg;

    // Fixed field widths of the block's item and register formats.
    localparam int ADDR_W   = 40;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 16;
    localparam int CFG_IDX_W = 1;

    // Defaults of the top-level parameters.
    localparam int DEF_PAGE_SHIFT = 12;
    localparam int DEF_MAX_PAGES  = 32768;

    // Register reset values.
    localparam logic [ADDR_W-1:0] RST_POOL_START = 40'h00_8000_0000;
    localparam logic [ADDR_W-1:0] RST_POOL_END   = 40'h00_8800_0000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_END   = 1'b1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLIPPED  = 3'd4;

    // Commands from the item logic to the freed-page stack.
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } t_stk_ctl;

endpackage

>>> design/page_free_list_allocator_core.sv
// Top level of the LIFO page allocator: stream handshake, work and result registers.
// Depends on pfla_pkg, pfla_exec and pfla_stack.
//
// Page allocator with last-in-first-out reuse. A beat is taken into a work
// register and decided there, and its result is then registered in the
// output register once that is free or being emptied. One beat is accepted
// every cycle while the output side takes results; the rate is set by the
// stack memory, which has one write port and one registered read port and
// always prefetches the entry below the next top of stack, so back-to-back
// allocations and frees run at one per cycle. After an init beat the first
// allocation returns the highest page of the pool. The pool registers may be
// written only while no beat is in flight. The freed-page memory holds
// MAX_PAGES entries and needs no clearing after reset.
module page_free_list_allocator_core
    import pfla_pkg::*;
#(
    parameter int PAGE_SHIFT = DEF_PAGE_SHIFT,
    parameter int MAX_PAGES  = DEF_MAX_PAGES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_wdata,
    // Request stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [ADDR_W-1:0]    s_axis_tdata,   // [39:0] page_addr
    input  logic [OP_W-1:0]      s_axis_tuser,   // [1:0] opcode
    // Result stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [ADDR_W+COUNT_W-1:0] m_axis_tdata, // [39:0] result_addr, [55:40] free_count
    output logic [STATUS_W-1:0]  m_axis_tuser    // [2:0] status
);

    localparam int PAGE_W  = ADDR_W - PAGE_SHIFT;
    localparam int DEPTH_W = $clog2(MAX_PAGES + 1);
    localparam int IDX_W   = $clog2(MAX_PAGES);

    logic                r_in_valid;
    logic [OP_W-1:0]     r_in_op;
    logic [ADDR_W-1:0]   r_in_addr;
    logic                r_out_valid;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [STATUS_W-1:0] r_out_status;
    logic [COUNT_W-1:0]  r_out_count;
    logic                advance;
    logic                in_beat;
    t_stk_ctl            stk_ctl;
    logic [PAGE_W-1:0]   push_page;
    logic [DEPTH_W-1:0]  stk_depth;
    logic [PAGE_W-1:0]   stk_top;
    logic [ADDR_W-1:0]   res_addr;
    logic [STATUS_W-1:0] res_status;
    logic [COUNT_W-1:0]  res_count;

    // Handshake: the work register moves on when the output register is free
    // or being emptied in the same cycle.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // Work register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_beat) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in_op   <= s_axis_tuser;
            r_in_addr <= s_axis_tdata;
        end
    end

    pfla_exec #(
        .PAGE_SHIFT (PAGE_SHIFT),
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_W     (PAGE_W),
        .DEPTH_W    (DEPTH_W)
    ) u_exec (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_go          (advance),
        .i_op          (r_in_op),
        .i_addr        (r_in_addr),
        .i_depth       (stk_depth),
        .i_top         (stk_top),
        .o_ctl         (stk_ctl),
        .o_push_page   (push_page),
        .o_result_addr (res_addr),
        .o_status      (res_status),
        .o_free_count  (res_count)
    );

    pfla_stack #(
        .PAGE_W    (PAGE_W),
        .MAX_PAGES (MAX_PAGES),
        .DEPTH_W   (DEPTH_W),
        .IDX_W     (IDX_W)
    ) u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (stk_ctl),
        .i_push_page (push_page),
        .o_depth     (stk_depth),
        .o_top       (stk_top)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_addr   <= res_addr;
            r_out_status <= res_status;
            r_out_count  <= res_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_count, r_out_addr};
    assign m_axis_tuser  = r_out_status;

endmodule

>>> design/pfla_stack.sv
// Freed-page stack: memory of page numbers with the top entry held in a register.
// Depends on pfla_pkg for the command struct.
module pfla_stack
    import pfla_pkg::*;
#(
    parameter int PAGE_W    = ADDR_W - DEF_PAGE_SHIFT,
    parameter int MAX_PAGES = DEF_MAX_PAGES,
    parameter int DEPTH_W   = $clog2(MAX_PAGES + 1),
    parameter int IDX_W     = $clog2(MAX_PAGES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_stk_ctl           i_ctl,
    input  logic [PAGE_W-1:0]  i_push_page,
    output logic [DEPTH_W-1:0] o_depth,
    output logic [PAGE_W-1:0]  o_top
);

    logic [PAGE_W-1:0]  r_mem [MAX_PAGES];
    logic [DEPTH_W-1:0] r_depth;
    logic [DEPTH_W-1:0] n_depth;
    logic [DEPTH_W-1:0] rd_sub;
    logic [IDX_W-1:0]   rd_addr;
    logic [PAGE_W-1:0]  r_rd;
    logic [PAGE_W-1:0]  r_top;

    // Next depth from the command of this cycle.
    always_comb begin
        n_depth = r_depth;
        if (i_ctl.clear) begin
            n_depth = '0;
        end else if (i_ctl.push) begin
            n_depth = r_depth + DEPTH_W'(1);
        end else if (i_ctl.pop) begin
            n_depth = r_depth - DEPTH_W'(1);
        end
    end

    // Prefetch the entry just below the next top, so a pop can refill the
    // top register in the following cycle.
    assign rd_sub  = n_depth - DEPTH_W'(2);
    assign rd_addr = rd_sub[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else begin
            r_depth <= n_depth;
        end
    end

    // Memory: one write port at the current depth, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push && !i_ctl.clear) begin
            r_mem[r_depth[IDX_W-1:0]] <= i_push_page;
        end
        r_rd <= r_mem[rd_addr];
    end

    // Top of stack register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push && !i_ctl.clear) begin
            r_top <= i_push_page;
        end else if (i_ctl.pop && !i_ctl.clear) begin
            r_top <= r_rd;
        end
    end

    assign o_depth = r_depth;
    assign o_top   = r_top;

endmodule

>>> design/pfla_exec.sv
// Item logic: pool registers, descending frontier and the decision for each beat.
// Depends on pfla_pkg; drives pfla_stack through a t_stk_ctl command.
module pfla_exec
    import pfla_pkg::*;
#(
    parameter int PAGE_SHIFT = DEF_PAGE_SHIFT,
    parameter int MAX_PAGES  = DEF_MAX_PAGES,
    parameter int PAGE_W     = ADDR_W - PAGE_SHIFT,
    parameter int DEPTH_W    = $clog2(MAX_PAGES + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_wdata,
    input  logic                 i_go,
    input  logic [OP_W-1:0]      i_op,
    input  logic [ADDR_W-1:0]    i_addr,
    input  logic [DEPTH_W-1:0]   i_depth,
    input  logic [PAGE_W-1:0]    i_top,
    output t_stk_ctl             o_ctl,
    output logic [PAGE_W-1:0]    o_push_page,
    output logic [ADDR_W-1:0]    o_result_addr,
    output logic [STATUS_W-1:0]  o_status,
    output logic [COUNT_W-1:0]   o_free_count
);

    localparam int SUM_W = DEPTH_W + 1;
    localparam logic [ADDR_W:0] PAGE_MASK = (ADDR_W + 1)'((64'd1 << PAGE_SHIFT) - 64'd1);
    localparam logic [ADDR_W:0] RST_START_RND = {1'b0, RST_POOL_START} + PAGE_MASK;
    localparam logic [PAGE_W:0] RST_FIRST_PG = RST_START_RND[ADDR_W:PAGE_SHIFT];
    localparam logic [PAGE_W-1:0] RST_STOP_PG = RST_POOL_END[ADDR_W-1:PAGE_SHIFT];
    localparam logic [PAGE_W:0] MAX_CNT = (PAGE_W + 1)'(MAX_PAGES);
    localparam logic [SUM_W-1:0] MAX_SUM = SUM_W'(MAX_PAGES);
    localparam logic [SUM_W-1:0] CNT_TOP = SUM_W'((64'd1 << COUNT_W) - 64'd1);

    logic [ADDR_W-1:0]  r_pool_start;
    logic [ADDR_W-1:0]  r_pool_end;
    logic [PAGE_W:0]    r_first_pg;
    logic [PAGE_W-1:0]  r_stop_pg;
    logic [ADDR_W:0]    cfg_rnd;
    logic [PAGE_W-1:0]  r_front_pg;
    logic [PAGE_W-1:0]  n_front_pg;
    logic [DEPTH_W-1:0] r_front_left;
    logic [DEPTH_W-1:0] n_front_left;
    logic [DEPTH_W-1:0] n_depth;
    logic [PAGE_W:0]    stop_ext;
    logic [PAGE_W:0]    init_cnt;
    logic               bad_free;
    logic [SUM_W-1:0]   cnt_sum;
    logic [SUM_W-1:0]   cnt_clip;

    // Pool registers; the page bounds are derived once, at write time.
    assign cfg_rnd = {1'b0, i_cfg_wdata} + PAGE_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_start <= RST_POOL_START;
            r_pool_end   <= RST_POOL_END;
            r_first_pg   <= RST_FIRST_PG;
            r_stop_pg    <= RST_STOP_PG;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_POOL_START: begin
                    r_pool_start <= i_cfg_wdata;
                    r_first_pg   <= cfg_rnd[ADDR_W:PAGE_SHIFT];
                end
                CFG_POOL_END: begin
                    r_pool_end <= i_cfg_wdata;
                    r_stop_pg  <= i_cfg_wdata[ADDR_W-1:PAGE_SHIFT];
                end
                default: begin
                end
            endcase
        end
    end

    // Pool size and free-address checks.
    assign stop_ext = {1'b0, r_stop_pg};
    assign init_cnt = stop_ext - r_first_pg;
    assign bad_free = (|i_addr[PAGE_SHIFT-1:0]) || (i_addr < r_pool_start)
                      || (i_addr >= r_pool_end);
    assign o_push_page = i_addr[ADDR_W-1:PAGE_SHIFT];

    // Decision for the beat in the work register.
    always_comb begin
        o_ctl         = '0;
        o_result_addr = '0;
        o_status      = ST_OK;
        n_front_pg    = r_front_pg;
        n_front_left  = r_front_left;
        n_depth       = i_depth;
        case (i_op)
            OP_INIT: begin
                o_ctl.clear  = 1'b1;
                n_depth      = '0;
                n_front_pg   = '0;
                n_front_left = '0;
                if (stop_ext > r_first_pg) begin
                    n_front_pg = r_stop_pg - PAGE_W'(1);
                    if (init_cnt > MAX_CNT) begin
                        n_front_left = DEPTH_W'(MAX_PAGES);
                        o_status     = ST_CLIPPED;
                    end else begin
                        n_front_left = init_cnt[DEPTH_W-1:0];
                    end
                end
            end
            OP_ALLOC: begin
                if (i_depth != '0) begin
                    o_ctl.pop     = 1'b1;
                    n_depth       = i_depth - DEPTH_W'(1);
                    o_result_addr = {i_top, {PAGE_SHIFT{1'b0}}};
                end else if (r_front_left != '0) begin
                    o_result_addr = {r_front_pg, {PAGE_SHIFT{1'b0}}};
                    n_front_left  = r_front_left - DEPTH_W'(1);
                    if (r_front_pg != '0) begin
                        n_front_pg = r_front_pg - PAGE_W'(1);
                    end
                end else begin
                    o_status = ST_EMPTY;
                end
            end
            OP_FREE: begin
                if (bad_free) begin
                    o_status = ST_BAD_FREE;
                end else if (i_depth >= DEPTH_W'(MAX_PAGES)) begin
                    o_status = ST_OVERFLOW;
                end else begin
                    o_ctl.push = 1'b1;
                    n_depth    = i_depth + DEPTH_W'(1);
                end
            end
            default: begin
            end
        endcase
        if (!i_go) begin
            o_ctl = '0;
        end
    end

    // Free pages after the beat, saturated at the pool limit and the field width.
    assign cnt_sum = {1'b0, n_depth} + {1'b0, n_front_left};

    always_comb begin
        cnt_clip = cnt_sum;
        if (cnt_clip > MAX_SUM) begin
            cnt_clip = MAX_SUM;
        end
        if (cnt_clip > CNT_TOP) begin
            cnt_clip = CNT_TOP;
        end
    end

    assign o_free_count = COUNT_W'(cnt_clip);

    // Frontier state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_pg   <= '0;
            r_front_left <= '0;
        end else if (i_go) begin
            r_front_pg   <= n_front_pg;
            r_front_left <= n_front_left;
        end
    end

endmodule

>>> dv/tb_top.sv
// Self-checking bench for the LIFO page allocator: directed table, stack burst, random phases.
// Depends on pfla_pkg and page_free_list_allocator_core; results are predicted inside the bench.
module tb_top;
    import pfla_pkg::*;

    localparam int PG_SHIFT = DEF_PAGE_SHIFT;
    localparam int PG_LIMIT = DEF_MAX_PAGES;
    localparam int PN_W     = ADDR_W - PG_SHIFT;
    localparam logic [ADDR_W-1:0] PG_BYTES = ADDR_W'(1) << PG_SHIFT;
    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
    // Opcode 3 has no function and must act as a no-op.
    localparam logic [OP_W-1:0] OP_NOP = 2'd3;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 194;
    localparam int HOLD_CYCLES   = 300;
    localparam int STACK_BURST   = 100;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } t_alloc_res;

    typedef enum logic {ROW_ITEM, ROW_POOL} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;     // page address, or pool start for pool rows
        logic [ADDR_W-1:0] pool_hi;  // pool end for pool rows
        logic              typed;    // use res below instead of the prediction
        t_alloc_res        res;
    } t_stim_row;

    logic                      i_clk;
    logic                      i_rst_n       = 1'b0;
    logic                      i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index   = CFG_POOL_START;
    logic [ADDR_W-1:0]         i_cfg_wdata   = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [ADDR_W-1:0]         s_axis_tdata  = '0;       // [39:0] page_addr
    logic [OP_W-1:0]           s_axis_tuser  = OP_INIT;  // [1:0] opcode
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [ADDR_W+COUNT_W-1:0] m_axis_tdata;             // [39:0] result_addr, [55:40] free_count
    logic [STATUS_W-1:0]       m_axis_tuser;             // [2:0] status

    page_free_list_allocator_core #(
        .PAGE_SHIFT(PG_SHIFT),
        .MAX_PAGES (PG_LIMIT)
    ) u_dut (.*);

    // Predictor state: pool bounds, freed-page stack and descending frontier.
    logic [ADDR_W-1:0] pool_lo;
    logic [ADDR_W-1:0] pool_hi;
    logic [PN_W-1:0]   stacked_pages [PG_LIMIT];
    int unsigned       stacked_cnt;
    int unsigned       frontier_cnt;
    logic [PN_W-1:0]   next_frontier;

    t_alloc_res        pending_results[$];
    logic [ADDR_W-1:0] held_pages[$];
    bit                idle_on      = 1'b1;
    bit                hold_request = 1'b0;
    int                err_cnt       = 0;
    int                beats_sent    = 0;
    int                beats_checked = 0;
    int                pool_writes   = 0;
    int                status_seen [8] = '{default: 0};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Works out the result of one request beat and advances the predictor state.
    function automatic t_alloc_res next_alloc_result(logic [OP_W-1:0] op,
                                                     logic [ADDR_W-1:0] addr);
        t_alloc_res        r;
        logic [ADDR_W:0]   first_pg;
        logic [ADDR_W:0]   stop_pg;
        int unsigned       total;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_INIT: begin
                first_pg = ({1'b0, pool_lo} + (PG_BYTES - 1)) >> PG_SHIFT;
                stop_pg  = {1'b0, pool_hi} >> PG_SHIFT;
                stacked_cnt   = 0;
                frontier_cnt  = 0;
                next_frontier = '0;
                if (stop_pg > first_pg) begin
                    // Only the highest pages are kept when the range is too large.
                    if (stop_pg - first_pg > PG_LIMIT) begin
                        frontier_cnt = PG_LIMIT;
                        r.status = ST_CLIPPED;
                    end else begin
                        frontier_cnt = int'(stop_pg - first_pg);
                    end
                    next_frontier = PN_W'(stop_pg - 1);
                end
            end
            OP_ALLOC: begin
                if (stacked_cnt > 0) begin
                    stacked_cnt--;
                    r.addr = ADDR_W'(stacked_pages[stacked_cnt]) << PG_SHIFT;
                end else if (frontier_cnt > 0) begin
                    r.addr = ADDR_W'(next_frontier) << PG_SHIFT;
                    frontier_cnt--;
                    if (next_frontier != 0) next_frontier--;
                end else begin
                    r.status = ST_EMPTY;
                end
            end
            OP_FREE: begin
                if ((addr & (PG_BYTES - 1)) != 0 || addr < pool_lo || addr >= pool_hi) begin
                    r.status = ST_BAD_FREE;
                end else if (stacked_cnt >= PG_LIMIT) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    stacked_pages[stacked_cnt] = addr[ADDR_W-1:PG_SHIFT];
                    stacked_cnt++;
                end
            end
            default: ;
        endcase
        // The free count saturates at the pool capacity and at the field maximum.
        total = stacked_cnt + frontier_cnt;
        if (total > PG_LIMIT) total = PG_LIMIT;
        if (total > 16'hFFFF) total = 16'hFFFF;
        r.count = COUNT_W'(total);
        return r;
    endfunction

    function automatic t_stim_row item_row(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
        t_stim_row row;
        row = '0;
        row.kind = ROW_ITEM;
        row.op   = op;
        row.addr = addr;
        return row;
    endfunction

    function automatic t_stim_row chk_row(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                          logic [ADDR_W-1:0] res_addr,
                                          logic [STATUS_W-1:0] res_status,
                                          logic [COUNT_W-1:0] res_count);
        t_stim_row row;
        row = item_row(op, addr);
        row.typed      = 1'b1;
        row.res.addr   = res_addr;
        row.res.status = res_status;
        row.res.count  = res_count;
        return row;
    endfunction

    function automatic t_stim_row pool_row(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
        t_stim_row row;
        row = '0;
        row.kind    = ROW_POOL;
        row.addr    = lo;
        row.pool_hi = hi;
        return row;
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {8'($urandom), $urandom};
    endfunction

    function automatic logic [ADDR_W-1:0] add_sat(logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ADDR_W] ? ADDR_MAX : s[ADDR_W-1:0];
    endfunction

    // Aligned page address from a random point of the pool range, or any one if the range is empty.
    function automatic logic [ADDR_W-1:0] pool_page();
        logic [ADDR_W-1:0] a;
        if (pool_hi <= pool_lo) return rand_addr() & ~(PG_BYTES - 1);
        a = pool_lo + rand_addr() % (pool_hi - pool_lo);
        return a & ~(PG_BYTES - 1);
    endfunction

    // Offers one request beat, after a random gap while idling is on, and records its expected result.
    task automatic send_item(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                             logic typed, t_alloc_res typed_res);
        int         gap;
        t_alloc_res pred;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= addr;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        pred = next_alloc_result(op, addr);
        pending_results.push_back(typed ? typed_res : pred);
        if (op == OP_INIT) held_pages.delete();
        if (op == OP_ALLOC && pred.status == ST_OK) held_pages.push_back(pred.addr);
        beats_sent++;
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Writes both pool registers on back-to-back cycles.
    task automatic write_pool(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_POOL_START;
        i_cfg_wdata <= lo;
        @(posedge i_clk);
        i_cfg_index <= CFG_POOL_END;
        i_cfg_wdata <= hi;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        pool_lo = lo;
        pool_hi = hi;
        pool_writes++;
    endtask

    // One random phase: a new pool, an init, then mostly alloc/free traffic.
    task automatic run_random_phase(int mode, int n_items, bit squeeze);
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] a;
        int                pick;
        int                idx;
        case (mode)
            0: begin
                // A handful of pages, so the pool runs empty often.
                lo = rand_addr();
                hi = add_sat(lo, (ADDR_W'($urandom_range(0, 24)) << PG_SHIFT)
                                 + (ADDR_W'($urandom) & (PG_BYTES - 1)));
            end
            1: begin
                // Right around the capacity, clipped or not.
                lo = rand_addr();
                hi = add_sat(lo, ADDR_W'($urandom_range(PG_LIMIT - 40, PG_LIMIT + 40)) << PG_SHIFT);
            end
            2: begin
                // Fully random bounds: often huge, often inverted.
                lo = rand_addr();
                hi = rand_addr();
            end
            default: begin
                // Near address zero, so the frontier can run down to page zero.
                lo = ADDR_W'($urandom_range(0, 5 << PG_SHIFT));
                hi = add_sat(lo, ADDR_W'($urandom_range(0, 40 << PG_SHIFT)));
            end
        endcase
        drain_results();
        write_pool(lo, hi);
        send_item(OP_INIT, rand_addr(), 1'b0, '0);
        if (squeeze) hold_request = 1'b1;
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                send_item(OP_INIT, rand_addr(), 1'b0, '0);
            end else if (pick < 6) begin
                send_item(OP_NOP, rand_addr(), 1'b0, '0);
            end else if (pick < 46) begin
                send_item(OP_ALLOC, rand_addr(), 1'b0, '0);
            end else if (pick < 78 && held_pages.size() != 0) begin
                // Give back a page that was handed out earlier.
                idx = $urandom_range(0, held_pages.size() - 1);
                a = held_pages[idx];
                held_pages.delete(idx);
                send_item(OP_FREE, a, 1'b0, '0);
            end else if (pick < 90) begin
                send_item(OP_FREE, pool_page(), 1'b0, '0);
            end else if (pick < 95) begin
                send_item(OP_FREE, pool_page() | ADDR_W'($urandom_range(1, PG_BYTES - 1)),
                          1'b0, '0);
            end else begin
                send_item(OP_FREE, rand_addr(), 1'b0, '0);
            end
        end
    endtask

    // Result side: random stalls while idling is on, plus one long hold-off when asked for.
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            stall = idle_on ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    task automatic note_mismatch(string what, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
        err_cnt++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    endtask

    // Compare every result beat with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_alloc_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_checked++;
            status_seen[m_axis_tuser]++;
            if (pending_results.size() == 0) begin
                err_cnt++;
                $display("%0t: result beat with nothing expected, expected none, got %h/%h",
                         $time, m_axis_tdata, m_axis_tuser);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[ADDR_W-1:0] !== want.addr)
                    note_mismatch("result_addr", want.addr, m_axis_tdata[ADDR_W-1:0]);
                if (m_axis_tuser !== want.status)
                    note_mismatch("status", ADDR_W'(want.status), ADDR_W'(m_axis_tuser));
                if (m_axis_tdata[ADDR_W+COUNT_W-1:ADDR_W] !== want.count)
                    note_mismatch("free_count", ADDR_W'(want.count),
                                  ADDR_W'(m_axis_tdata[ADDR_W+COUNT_W-1:ADDR_W]));
            end
        end
    end

    // Main sequence.
    initial begin
        t_stim_row plan[$];
        pool_lo       = RST_POOL_START;
        pool_hi       = RST_POOL_END;
        stacked_cnt   = 0;
        frontier_cnt  = 0;
        next_frontier = '0;

        // Reset pool, before and after the first init.
        plan.push_back(chk_row(OP_ALLOC, '0, '0, ST_EMPTY, 16'd0));
        plan.push_back(chk_row(OP_FREE, 40'h00_8000_0000, '0, ST_OK, 16'd1));
        plan.push_back(chk_row(OP_ALLOC, '0, 40'h00_8000_0000, ST_OK, 16'd0));
        plan.push_back(chk_row(OP_NOP, ADDR_MAX, '0, ST_OK, 16'd0));
        plan.push_back(chk_row(OP_INIT, '0, '0, ST_OK, 16'd32768));
        plan.push_back(chk_row(OP_ALLOC, '0, 40'h00_87FF_F000, ST_OK, 16'd32767));
        plan.push_back(chk_row(OP_FREE, 40'h00_87FF_F001, '0, ST_BAD_FREE, 16'd32767));
        plan.push_back(chk_row(OP_FREE, 40'h00_7FFF_F000, '0, ST_BAD_FREE, 16'd32767));
        plan.push_back(chk_row(OP_FREE, 40'h00_8800_0000, '0, ST_BAD_FREE, 16'd32767));
        plan.push_back(chk_row(OP_FREE, 40'h00_8000_0000, '0, ST_OK, 16'd32768));
        // Double free is pushed again, and the count saturates.
        plan.push_back(chk_row(OP_FREE, 40'h00_8000_0000, '0, ST_OK, 16'd32768));
        plan.push_back(chk_row(OP_ALLOC, '0, 40'h00_8000_0000, ST_OK, 16'd32768));
        // Init again discards the stacked pages.
        plan.push_back(chk_row(OP_INIT, '0, '0, ST_OK, 16'd32768));
        // Whole address space: clipped to the highest pages.
        plan.push_back(pool_row('0, ADDR_MAX));
        plan.push_back(chk_row(OP_INIT, '0, '0, ST_CLIPPED, 16'd32768));
        plan.push_back(chk_row(OP_ALLOC, '0, 40'hFF_FFFF_E000, ST_OK, 16'd32767));
        plan.push_back(chk_row(OP_FREE, '0, '0, ST_OK, 16'd32768));
        plan.push_back(chk_row(OP_FREE, ADDR_MAX, '0, ST_BAD_FREE, 16'd32768));
        plan.push_back(chk_row(OP_ALLOC, '0, '0, ST_OK, 16'd32767));
        plan.push_back(item_row(OP_FREE, 40'hFF_FFFF_F000));
        plan.push_back(item_row(OP_ALLOC, '0));
        // No whole page between the bounds.
        plan.push_back(pool_row(40'h1001, 40'h2FFF));
        plan.push_back(chk_row(OP_INIT, '0, '0, ST_OK, 16'd0));
        // Two pages at the bottom: the frontier stops at page zero.
        plan.push_back(pool_row('0, 40'h2000));
        plan.push_back(item_row(OP_INIT, '0));
        plan.push_back(item_row(OP_ALLOC, '0));
        plan.push_back(item_row(OP_ALLOC, '0));
        plan.push_back(item_row(OP_ALLOC, '0));
        plan.push_back(item_row(OP_FREE, 40'h1000));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_POOL) begin
                drain_results();
                write_pool(plan[k].addr, plan[k].pool_hi);
            end else begin
                send_item(plan[k].op, plan[k].addr, plan[k].typed, plan[k].res);
            end
        end

        // Back-to-back frees stack up pages, then pops run past them into the frontier.
        drain_results();
        idle_on = 1'b0;
        write_pool(RST_POOL_START, RST_POOL_END);
        send_item(OP_INIT, '0, 1'b0, '0);
        repeat (STACK_BURST)
            send_item(OP_FREE,
                      RST_POOL_START
                      + (ADDR_W'($urandom_range(0, PG_LIMIT - 1)) << PG_SHIFT),
                      1'b0, '0);
        repeat (STACK_BURST + 2) send_item(OP_ALLOC, rand_addr(), 1'b0, '0);

        // Random phases: one with the long result hold-off, one without idling.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            idle_on = (ph != 4);
            run_random_phase(ph % 4, PHASE_ITEMS, ph == 1);
        end
        idle_on = 1'b1;

        drain_results();
        repeat (10) @(posedge i_clk);
        $display("tb_top: %0d request beats, %0d result beats checked, %0d pool settings",
                 beats_sent, beats_checked, pool_writes);
        $display("tb_top: status mix ok=%0d empty=%0d bad_free=%0d overflow=%0d clipped=%0d",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_BAD_FREE],
                 status_seen[ST_OVERFLOW], status_seen[ST_CLIPPED]);
        if (err_cnt == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #40000000;
        $display("tb_top: timeout with %0d results outstanding", pending_results.size());
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> page_free_list_allocator_core.f
design/pfla_pkg.sv
design/pfla_stack.sv
design/pfla_exec.sv
design/page_free_list_allocator_core.sv
dv/tb_top.sv
